[design/smsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skip/copy movie stream decoder package
// Shared widths, parameter defaults and the skip unit result type.
// ----------------------------------------------------------------------------
package smsd_pkg;

    localparam int BYTE_W                 = 8;
    localparam int COUNT_W                = 16;
    localparam int ADDR_W                 = 19;
    localparam int POS_W                  = 18;
    localparam int RING_W                 = 16;
    localparam int LEFT_W                 = 18;
    localparam int LINE_STRIDE            = 512;
    localparam int COL_W                  = $clog2(LINE_STRIDE);

    localparam int DEF_LINE_PIXELS        = 320;
    localparam int DEF_SOUND_RING_SAMPLES = 65536;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
    } t_skip_result;

endpackage

[design/smsd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skip/copy movie stream decoder channels
// Byte input channel and byte write result channel with valid/ready.
// ----------------------------------------------------------------------------
interface smsd_in_if;
    import smsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

interface smsd_out_if;
    import smsd_pkg::*;

    logic              valid;
    logic              ready;
    logic              write_enable;
    logic              target;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] write_data;
    logic              frame_done;

    modport source (output valid, output write_enable, output target,
                    output byte_address, output write_data, output frame_done,
                    input ready);
    modport sink (input valid, input write_enable, input target,
                  input byte_address, input write_data, input frame_done,
                  output ready);
endinterface

[design/skip_copy_movie_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skip/copy movie stream decoder
// Turns the movie byte stream into byte writes to video and sound memory.
// ----------------------------------------------------------------------------
// The i_stream channel takes one stream byte per transfer, starting with the
// first byte after the file header. The o_result channel gives one byte write
// per transfer, to video memory or to the sound ring, and flags the transfer
// that completes a frame's sound chunk. Bytes that only carry counts give no
// transfer, but a zero sound count can give a flag-only transfer on o_result.
// One byte is taken per cycle while the output register is empty or being
// emptied. A result enters the output register as its byte is taken. A skip
// count moves the screen position in the cycle after its low byte, through
// the reciprocal multiply of the skip unit, before any copied pixel needs it.
// When the receiver stalls, the output register holds its result and the next
// byte is still taken if it is being emptied in the same cycle.
// The user writes the sixteen bit audio register through i_cfg_wr_en only
// while the block is idle, which it does not enforce. Reset sets it, empties
// the output register and returns the parser to the opening sound chunk.
// ----------------------------------------------------------------------------
module skip_copy_movie_stream_decoder_unit #(
    parameter int LINE_PIXELS        = smsd_pkg::DEF_LINE_PIXELS,
    parameter int SOUND_RING_SAMPLES = smsd_pkg::DEF_SOUND_RING_SAMPLES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic      i_cfg_wr_data,
    smsd_in_if.sink   i_stream,
    smsd_out_if.source o_result
);
    import smsd_pkg::*;

    localparam logic [2:0] PH_SND_HI    = 3'd0;
    localparam logic [2:0] PH_SND_LO    = 3'd1;
    localparam logic [2:0] PH_SND_DATA  = 3'd2;
    localparam logic [2:0] PH_SKIP_HI   = 3'd3;
    localparam logic [2:0] PH_SKIP_LO   = 3'd4;
    localparam logic [2:0] PH_COPY_HI   = 3'd5;
    localparam logic [2:0] PH_COPY_LO   = 3'd6;
    localparam logic [2:0] PH_COPY_DATA = 3'd7;

    localparam logic [COUNT_W-1:0] END_MARK  = '1;
    localparam logic [RING_W-1:0]  RING_LAST = RING_W'(SOUND_RING_SAMPLES - 1);

    function automatic logic [POS_W-1:0] next_line(input logic [POS_W-1:0] pos);
        next_line = {pos[POS_W-1:COL_W] + 1'b1, COL_W'(0)};
    endfunction

    logic [2:0]         r_phase, n_phase;
    logic [BYTE_W-1:0]  r_high, n_high;
    logic [LEFT_W-1:0]  r_bytes_left, n_bytes_left;
    logic [POS_W-1:0]   r_screen, n_screen;
    logic               r_pix_idx, n_pix_idx;
    logic [RING_W-1:0]  r_ring_pos, n_ring_pos;
    logic               r_frame_started, n_frame_started;
    logic               r_sixteen;

    logic               r_out_valid;
    logic               r_we;
    logic               r_target;
    logic [ADDR_W-1:0]  r_addr;
    logic [BYTE_W-1:0]  r_data;
    logic               r_done;

    logic               w_accept;
    logic [BYTE_W-1:0]  w_byte;
    logic [COUNT_W-1:0] w_count;
    logic [LEFT_W-1:0]  w_left_dec;
    logic [RING_W-1:0]  w_ring_inc;
    logic [POS_W-1:0]   w_pos;
    logic               w_skip_start;
    t_skip_result       w_skip;

    logic               n_we;
    logic               n_target;
    logic [ADDR_W-1:0]  n_addr;
    logic               n_done;

    assign i_stream.ready = !r_out_valid || o_result.ready;
    assign w_accept       = i_stream.valid && i_stream.ready;
    assign w_byte         = i_stream.stream_byte;
    assign w_count        = {r_high, w_byte};
    assign w_left_dec     = r_bytes_left - 1'b1;
    assign w_ring_inc     = (r_ring_pos == RING_LAST) ? '0 : r_ring_pos + 1'b1;
    assign w_skip_start   = w_accept && (r_phase == PH_SKIP_LO) && (w_count != END_MARK);

    smsd_skip_step #(
        .LINE_PIXELS(LINE_PIXELS)
    ) u_skip_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_skip_start),
        .i_count    (w_count),
        .i_position (r_screen),
        .o_skip     (w_skip)
    );

    always_comb begin
        n_phase         = r_phase;
        n_high          = r_high;
        n_bytes_left    = r_bytes_left;
        n_screen        = w_skip.valid ? w_skip.position : r_screen;
        n_pix_idx       = r_pix_idx;
        n_ring_pos      = r_ring_pos;
        n_frame_started = r_frame_started;
        n_we            = 1'b0;
        n_target        = 1'b0;
        n_addr          = '0;
        n_done          = 1'b0;
        w_pos           = r_screen;

        if (w_accept) begin
            unique case (r_phase) inside
                PH_SND_HI, PH_SKIP_HI, PH_COPY_HI: begin
                    n_high  = w_byte;
                    n_phase = r_phase + 3'd1;
                end
                PH_SND_LO: begin
                    n_pix_idx = 1'b0;
                    if (w_count == '0) begin
                        n_done          = r_frame_started;
                        n_frame_started = 1'b1;
                        n_phase         = PH_SKIP_HI;
                        n_screen        = '0;
                        n_bytes_left    = '0;
                    end else begin
                        n_bytes_left = r_sixteen ? {1'b0, w_count, 1'b0}
                                                 : LEFT_W'(w_count);
                        n_phase      = PH_SND_DATA;
                    end
                end
                PH_SND_DATA: begin
                    n_we     = 1'b1;
                    n_target = 1'b1;
                    if (r_sixteen) begin
                        n_addr = ADDR_W'({r_ring_pos, r_pix_idx});
                        if (r_pix_idx) begin
                            n_ring_pos = w_ring_inc;
                            n_pix_idx  = 1'b0;
                        end else begin
                            n_pix_idx = 1'b1;
                        end
                    end else begin
                        n_addr     = ADDR_W'(r_ring_pos);
                        n_ring_pos = w_ring_inc;
                        n_pix_idx  = 1'b0;
                    end
                    n_bytes_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_done          = r_frame_started;
                        n_frame_started = 1'b1;
                        n_phase         = PH_SKIP_HI;
                        n_screen        = '0;
                        n_pix_idx       = 1'b0;
                    end
                end
                PH_SKIP_LO: begin
                    n_phase = (w_count == END_MARK) ? PH_SND_HI : PH_COPY_HI;
                end
                PH_COPY_LO: begin
                    if (w_count == END_MARK) begin
                        n_phase = PH_SND_HI;
                    end else if (w_count == '0) begin
                        n_phase = PH_SKIP_HI;
                    end else begin
                        n_bytes_left = {1'b0, w_count, 1'b0};
                        n_pix_idx    = 1'b0;
                        n_phase      = PH_COPY_DATA;
                    end
                end
                PH_COPY_DATA: begin
                    if (!r_pix_idx &&
                        ({1'b0, r_screen[COL_W-1:0]} >= (COL_W+1)'(LINE_PIXELS))) begin
                        w_pos = next_line(r_screen);
                    end
                    n_we   = 1'b1;
                    n_addr = {w_pos, r_pix_idx};
                    n_screen = w_pos;
                    if (r_pix_idx) begin
                        n_pix_idx = 1'b0;
                        if (({1'b0, w_pos[COL_W-1:0]} + 1'b1) >=
                            (COL_W+1)'(LINE_PIXELS)) begin
                            n_screen = next_line(w_pos);
                        end else begin
                            n_screen = w_pos + 1'b1;
                        end
                    end else begin
                        n_pix_idx = 1'b1;
                    end
                    n_bytes_left = w_left_dec;
                    if (w_left_dec == '0) begin
                        n_pix_idx = 1'b0;
                        n_phase   = PH_SKIP_HI;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_SND_HI;
            r_high          <= '0;
            r_bytes_left    <= '0;
            r_screen        <= '0;
            r_pix_idx       <= 1'b0;
            r_ring_pos      <= '0;
            r_frame_started <= 1'b0;
            r_sixteen       <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_high          <= n_high;
            r_bytes_left    <= n_bytes_left;
            r_screen        <= n_screen;
            r_pix_idx       <= n_pix_idx;
            r_ring_pos      <= n_ring_pos;
            r_frame_started <= n_frame_started;
            if (i_cfg_wr_en) begin
                r_sixteen <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_out_valid <= n_we || n_done;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (n_we || n_done)) begin
            r_we     <= n_we;
            r_target <= n_target;
            r_addr   <= n_addr;
            r_data   <= n_we ? w_byte : '0;
            r_done   <= n_done;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.write_enable = r_we;
    assign o_result.target       = r_target;
    assign o_result.byte_address = r_addr;
    assign o_result.write_data   = r_data;
    assign o_result.frame_done   = r_done;

endmodule

[design/smsd_skip_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skip step unit
// Splits a skip count into whole lines and a remainder by a reciprocal
// multiply, then moves the screen position from the registered quotient.
// ----------------------------------------------------------------------------
module smsd_skip_step #(
    parameter int LINE_PIXELS = smsd_pkg::DEF_LINE_PIXELS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [smsd_pkg::COUNT_W-1:0] i_count,
    input  logic [smsd_pkg::POS_W-1:0]   i_position,
    output smsd_pkg::t_skip_result       o_skip
);
    import smsd_pkg::*;

    localparam int DIV_SHIFT = COUNT_W + $clog2(LINE_PIXELS);
    localparam int PROD_W    = DIV_SHIFT + COUNT_W;
    localparam int RECIP     = ((1 << DIV_SHIFT) + LINE_PIXELS - 1) / LINE_PIXELS;

    logic [PROD_W-1:0]  w_prod;
    logic [COUNT_W-1:0] r_quot;
    logic [COUNT_W-1:0] r_count;
    logic               r_valid;
    logic [COUNT_W-1:0] w_rem_full;
    logic [COL_W-1:0]   w_rem;
    logic [POS_W-1:0]   w_base;
    logic [COL_W:0]     w_col_sum;

    assign w_prod = PROD_W'(i_count) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot  <= w_prod[DIV_SHIFT +: COUNT_W];
            r_count <= i_count;
        end
    end

    assign w_rem_full = r_count - COUNT_W'(r_quot * COUNT_W'(LINE_PIXELS));
    assign w_rem      = w_rem_full[COL_W-1:0];
    assign w_base     = i_position + {r_quot[POS_W-COL_W-1:0], COL_W'(0)};
    assign w_col_sum  = {1'b0, w_rem} + {1'b0, w_base[COL_W-1:0]};

    always_comb begin
        o_skip.valid = r_valid;
        if (w_col_sum >= (COL_W+1)'(LINE_PIXELS)) begin
            o_skip.position = w_base + POS_W'(w_rem)
                            + POS_W'(LINE_STRIDE - LINE_PIXELS);
        end else begin
            o_skip.position = w_base + POS_W'(w_rem);
        end
    end

endmodule

[design/smsd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skip/copy movie stream decoder checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module smsd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_write_enable,
    input logic                        i_target,
    input logic [smsd_pkg::ADDR_W-1:0] i_byte_address,
    input logic [smsd_pkg::BYTE_W-1:0] i_write_data,
    input logic                        i_frame_done
);
    import smsd_pkg::*;

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Result valid dropped without a transfer.");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_byte_address) && $stable(i_write_data))
        else $error("Stalled result payload changed.");

    a_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_write_enable || i_frame_done)
        else $error("Result carries neither a write nor a frame end.");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_write_enable |->
            !i_target && (i_byte_address == '0) && (i_write_data == '0))
        else $error("Result without a write has non-zero fields.");

    a_done_on_sound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_done |-> !i_write_enable || i_target)
        else $error("Frame end flagged on a video write.");

endmodule

bind skip_copy_movie_stream_decoder_unit smsd_checker u_smsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_write_enable (o_result.write_enable),
    .i_target       (o_result.target),
    .i_byte_address (o_result.byte_address),
    .i_write_data   (o_result.write_data),
    .i_frame_done   (o_result.frame_done)
);

[verif/skip_copy_movie_stream_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skip/copy movie stream decoder testbench
// A short table of hand-made stream bytes opens the run: a sound chunk, a
// frame that copies across the end of a line, an empty sound chunk, an empty
// copy, ending mid-chunk, where the audio width then changes. Random streams
// follow. They are shaped from the live parse state, so that counts stay
// well formed, and they cover large skips, long copies, both end marks and
// empty chunks. A predictor of
// the decoder works out every byte write and frame end. Each result transfer
// is checked field by field against the oldest expected write. The sender
// works in bursts, and the receiver stalls in changing patterns, with long
// hold-offs that back the decoder up.
// ----------------------------------------------------------------------------
module skip_copy_movie_stream_decoder_unit_tb;
    import smsd_pkg::*;

    localparam int LINE_PIXELS     = DEF_LINE_PIXELS;
    localparam int RING_SAMPLES    = DEF_SOUND_RING_SAMPLES;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int CYCLE_LIMIT     = 6_000_000;

    localparam logic [COUNT_W-1:0] END_OF_PICTURE = 16'hFFFF;

    typedef enum logic [2:0] {
        SOUND_COUNT_HI,
        SOUND_COUNT_LO,
        SOUND_SAMPLES,
        SKIP_COUNT_HI,
        SKIP_COUNT_LO,
        COPY_COUNT_HI,
        COPY_COUNT_LO,
        COPY_PIXELS
    } t_stream_field;

    typedef enum logic [1:0] {
        ALWAYS_READY,
        COIN_FLIP,
        SPARSE_READY,
        MOSTLY_READY
    } t_stall_mode;

    typedef struct packed {
        logic              write_enable;
        logic              target;
        logic [ADDR_W-1:0] byte_address;
        logic [BYTE_W-1:0] write_data;
        logic              frame_done;
    } t_byte_write;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
        logic              pinned;
        logic              has_write;
        t_byte_write       expected_write;
    } t_stimulus_row;

    localparam t_byte_write NO_WRITE = '0;

    localparam t_stimulus_row DIRECTED_ROWS [25] = '{
        '{8'h00, 1'b1, 1'b0, NO_WRITE},
        '{8'h01, 1'b1, 1'b0, NO_WRITE},
        '{8'hFF, 1'b1, 1'b1, '{1'b1, 1'b1, 19'd0, 8'hFF, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{1'b1, 1'b1, 19'd1, 8'h00, 1'b0}},
        '{8'h01, 1'b0, 1'b0, NO_WRITE},
        '{8'h3F, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'h02, 1'b0, 1'b0, NO_WRITE},
        '{8'hA5, 1'b0, 1'b0, NO_WRITE},
        '{8'h5A, 1'b0, 1'b0, NO_WRITE},
        '{8'h3C, 1'b0, 1'b0, NO_WRITE},
        '{8'hC3, 1'b0, 1'b0, NO_WRITE},
        '{8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 19'd0, 8'h00, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{8'hFF, 1'b0, 1'b0, NO_WRITE},
        '{8'h00, 1'b0, 1'b0, NO_WRITE},
        '{8'h03, 1'b0, 1'b0, NO_WRITE},
        '{8'h80, 1'b1, 1'b1, '{1'b1, 1'b1, 19'd2, 8'h80, 1'b0}}
    };

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    smsd_in_if  stream_if ();
    smsd_out_if result_if ();

    skip_copy_movie_stream_decoder_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_stream      (stream_if),
        .o_result      (result_if)
    );

    t_stream_field     field_now   = SOUND_COUNT_HI;
    logic [BYTE_W-1:0] count_hi    = '0;
    logic [LEFT_W-1:0] bytes_to_go = '0;
    logic [POS_W-1:0]  screen_pos  = '0;
    logic              odd_byte    = 1'b0;
    logic [RING_W-1:0] ring_pos    = '0;
    logic              in_frame    = 1'b0;
    logic              wide_samples = 1'b1;

    t_byte_write       pending_writes [$];
    logic              pin_row = 1'b0;
    logic              pin_has = 1'b0;
    t_byte_write       pin_write = '0;
    logic [COUNT_W-1:0] planned_count = '0;
    int unsigned       results_seen = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count = 0;

    function automatic logic close_sound_chunk();
        logic closes_frame;
        closes_frame = in_frame;
        in_frame     = 1'b1;
        field_now    = SKIP_COUNT_HI;
        screen_pos   = '0;
        odd_byte     = 1'b0;
        bytes_to_go  = '0;
        return closes_frame;
    endfunction

    function automatic void step_to_next_line();
        screen_pos = POS_W'({screen_pos[POS_W-1:COL_W], {COL_W{1'b0}}} + LINE_STRIDE);
    endfunction

    task automatic decode_byte(input logic [BYTE_W-1:0] b, output logic produces,
                               output t_byte_write w);
        logic [COUNT_W-1:0] count;
        int unsigned        lines;
        int unsigned        rest;
        count    = {count_hi, b};
        produces = 1'b0;
        w        = '0;
        case (field_now)
            SOUND_COUNT_HI: begin
                count_hi  = b;
                field_now = SOUND_COUNT_LO;
            end
            SKIP_COUNT_HI: begin
                count_hi  = b;
                field_now = SKIP_COUNT_LO;
            end
            COPY_COUNT_HI: begin
                count_hi  = b;
                field_now = COPY_COUNT_LO;
            end
            SOUND_COUNT_LO: begin
                odd_byte = 1'b0;
                if (count == '0) begin
                    w.frame_done = close_sound_chunk();
                    produces     = w.frame_done;
                end else begin
                    bytes_to_go = wide_samples ? {1'b0, count, 1'b0} : {2'b00, count};
                    field_now   = SOUND_SAMPLES;
                end
            end
            SOUND_SAMPLES: begin
                w.write_enable = 1'b1;
                w.target       = 1'b1;
                w.write_data   = b;
                if (wide_samples) begin
                    w.byte_address = {2'b00, ring_pos, odd_byte};
                    if (odd_byte) begin
                        ring_pos = RING_W'((int'(ring_pos) + 1) % RING_SAMPLES);
                    end
                    odd_byte = !odd_byte;
                end else begin
                    w.byte_address = {3'b000, ring_pos};
                    ring_pos       = RING_W'((int'(ring_pos) + 1) % RING_SAMPLES);
                    odd_byte       = 1'b0;
                end
                bytes_to_go = bytes_to_go - 1'b1;
                if (bytes_to_go == '0) begin
                    w.frame_done = close_sound_chunk();
                end
                produces = 1'b1;
            end
            SKIP_COUNT_LO: begin
                if (count == END_OF_PICTURE) begin
                    field_now = SOUND_COUNT_HI;
                end else begin
                    lines      = count / LINE_PIXELS;
                    rest       = count % LINE_PIXELS;
                    screen_pos = POS_W'(screen_pos + lines * LINE_STRIDE);
                    if (rest + screen_pos[COL_W-1:0] >= LINE_PIXELS) begin
                        screen_pos = POS_W'(screen_pos + rest + LINE_STRIDE - LINE_PIXELS);
                    end else begin
                        screen_pos = POS_W'(screen_pos + rest);
                    end
                    field_now = COPY_COUNT_HI;
                end
            end
            COPY_COUNT_LO: begin
                if (count == END_OF_PICTURE) begin
                    field_now = SOUND_COUNT_HI;
                end else if (count == '0) begin
                    field_now = SKIP_COUNT_HI;
                end else begin
                    bytes_to_go = {1'b0, count, 1'b0};
                    odd_byte    = 1'b0;
                    field_now   = COPY_PIXELS;
                end
            end
            default: begin
                if (!odd_byte && screen_pos[COL_W-1:0] >= LINE_PIXELS) begin
                    step_to_next_line();
                end
                w.write_enable = 1'b1;
                w.target       = 1'b0;
                w.byte_address = {screen_pos, odd_byte};
                w.write_data   = b;
                if (odd_byte) begin
                    odd_byte = 1'b0;
                    if (screen_pos[COL_W-1:0] + 1 >= LINE_PIXELS) begin
                        step_to_next_line();
                    end else begin
                        screen_pos = screen_pos + 1'b1;
                    end
                end else begin
                    odd_byte = 1'b1;
                end
                bytes_to_go = bytes_to_go - 1'b1;
                if (bytes_to_go == '0) begin
                    odd_byte  = 1'b0;
                    field_now = SKIP_COUNT_HI;
                end
                produces = 1'b1;
            end
        endcase
    endtask

    // Counts are chosen on their high byte and finished on the low byte, so that
    // most of the stream stays in step with the parser.
    function automatic logic [BYTE_W-1:0] pick_stream_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (field_now)
            SOUND_COUNT_HI: begin
                if (roll < 20) begin
                    planned_count = '0;
                end else if (roll < 95) begin
                    planned_count = 16'($urandom_range(1, 12));
                end else begin
                    planned_count = 16'($urandom_range(13, 300));
                end
                return planned_count[15:8];
            end
            SKIP_COUNT_HI: begin
                if (roll < 20) begin
                    planned_count = END_OF_PICTURE;
                end else if (roll < 50) begin
                    planned_count = 16'($urandom_range(0, LINE_PIXELS - 1));
                end else if (roll < 75) begin
                    planned_count = 16'($urandom_range(LINE_PIXELS, 1500));
                end else begin
                    planned_count = 16'($urandom_range(0, 65534));
                end
                return planned_count[15:8];
            end
            COPY_COUNT_HI: begin
                if (roll < 15) begin
                    planned_count = END_OF_PICTURE;
                end else if (roll < 25) begin
                    planned_count = '0;
                end else if (roll < 92) begin
                    planned_count = 16'($urandom_range(1, 8));
                end else begin
                    planned_count = 16'($urandom_range(9, 400));
                end
                return planned_count[15:8];
            end
            SOUND_COUNT_LO, SKIP_COUNT_LO, COPY_COUNT_LO: begin
                return planned_count[7:0];
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic check_field(input string field, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        stream_if.valid       <= 1'b1;
        stream_if.stream_byte <= b;
        do begin
            @(posedge clk);
        end while (!(stream_if.valid === 1'b1 && stream_if.ready === 1'b1));
        @(negedge clk);
    endtask

    task automatic run_phase(input logic wide, input int unsigned items);
        int unsigned sent;
        int unsigned burst;
        while (pending_writes.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= wide;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sent = 0;
        while (sent < items) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && sent < items) begin
                send_byte(pick_stream_byte());
                sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) begin
                stream_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        stream_if.valid <= 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("skip_copy_movie_stream_decoder_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk) begin : monitor
        t_byte_write want;
        t_byte_write predicted;
        logic        produces;
        if (rst_n) begin
            if (cfg_wr_en) begin
                wide_samples = cfg_wr_data;
            end
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t ns: no transfer expected, got we=%0h tgt=%0h %s",
                             $time, result_if.write_enable, result_if.target,
                             $sformatf("addr=%0h data=%0h done=%0h",
                                       result_if.byte_address, result_if.write_data,
                                       result_if.frame_done));
                    mismatch_count++;
                end else begin
                    want = pending_writes.pop_front();
                    check_field("write_enable", ADDR_W'(want.write_enable),
                                ADDR_W'(result_if.write_enable));
                    check_field("target", ADDR_W'(want.target), ADDR_W'(result_if.target));
                    check_field("byte_address", want.byte_address, result_if.byte_address);
                    check_field("write_data", ADDR_W'(want.write_data),
                                ADDR_W'(result_if.write_data));
                    check_field("frame_done", ADDR_W'(want.frame_done),
                                ADDR_W'(result_if.frame_done));
                end
                results_seen++;
            end
            if (stream_if.valid === 1'b1 && stream_if.ready === 1'b1) begin
                decode_byte(stream_if.stream_byte, produces, predicted);
                if (pin_row) begin
                    produces  = pin_has;
                    predicted = pin_write;
                end
                if (produces) begin
                    pending_writes.push_back(predicted);
                end
            end
        end
    end

    initial begin : receiver
        t_stall_mode mode;
        int unsigned mode_left;
        int unsigned holdoff_left;
        int unsigned holdoffs_done;
        result_if.ready = 1'b0;
        mode            = ALWAYS_READY;
        mode_left       = 0;
        holdoff_left    = 0;
        holdoffs_done   = 0;
        forever begin
            @(negedge clk);
            if (holdoff_left == 0 && holdoffs_done < 2 &&
                results_seen >= (holdoffs_done == 0 ? 150 : 450)) begin
                holdoff_left = HOLD_OFF_CYCLES;
                holdoffs_done++;
            end
            if (mode_left == 0) begin
                mode      = t_stall_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (holdoff_left > 0) begin
                holdoff_left--;
                result_if.ready <= 1'b0;
            end else begin
                case (mode)
                    ALWAYS_READY: result_if.ready <= 1'b1;
                    COIN_FLIP:    result_if.ready <= 1'($urandom_range(0, 1));
                    SPARSE_READY: result_if.ready <= ($urandom_range(0, 3) == 0);
                    default:      result_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = 1'b0;
        stream_if.valid       = 1'b0;
        stream_if.stream_byte = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The table stops inside a 16-bit sound chunk, so the first random
        // phase switches the audio width mid-chunk.
        for (int r = 0; r < 25; r++) begin
            pin_row   = DIRECTED_ROWS[r].pinned;
            pin_has   = DIRECTED_ROWS[r].has_write;
            pin_write = DIRECTED_ROWS[r].expected_write;
            send_byte(DIRECTED_ROWS[r].stream_byte);
        end
        pin_row = 1'b0;
        stream_if.valid <= 1'b0;

        run_phase(1'b0, 250);
        run_phase(1'b1, 250);
        run_phase(1'b0, 250);
        run_phase(1'b1, 250);
        run_phase(1'b0, 225);

        while (pending_writes.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("skip_copy_movie_stream_decoder_unit: match");
        end else begin
            $display("skip_copy_movie_stream_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
